@@ rtl/bst_pkg.sv @@
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants of the byte shuffle transpose block.
// ----------------------------------------------------------------------------
package bst_pkg;

   // Buffer geometry
   localparam int BUF_BYTES = 4096;
   localparam int ADDR_W    = $clog2(BUF_BYTES);
   localparam int POS_W     = ADDR_W + 1;

   // Register field widths
   localparam int TYPE_CODE_W  = 2;
   localparam int ELEM_COUNT_W = 12;
   localparam int SHIFT_W      = TYPE_CODE_W + 1;
   localparam int MAX_SHIFT    = (1 << TYPE_CODE_W);
   localparam int LANE_W       = MAX_SHIFT + 1;
   localparam int BLK_W        = ELEM_COUNT_W + MAX_SHIFT + 1;
   localparam int CALC_W       = (BLK_W > POS_W) ? BLK_W : POS_W;

   // Register port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   // Register indexes (word address bit)
   localparam logic REG_TYPE_SIZE  = 1'b0;
   localparam logic REG_ELEM_COUNT = 1'b1;

   // Item modes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EMIT = 1'b1;

   // Status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       status;
   } rsp_payload_type;

   // Flags carried alongside a buffer read in flight
   typedef struct packed {
      logic valid;
      logic rd;
      logic last;
      logic status;
   } stage_type;

endpackage

@@ rtl/bst_ram.sv @@
// ----------------------------------------------------------------------------
// bst_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // hold the last read word until the next read
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/byte_shuffle_transpose.sv @@
// ----------------------------------------------------------------------------
// byte_shuffle_transpose
// Byte-shuffle prefilter: loads a block of elements byte by byte and emits it
// transposed, every element's first byte first, then every second byte, etc.
// ----------------------------------------------------------------------------
// Every request transfer yields exactly one response transfer, in order. A
// load transfer (mode 0) writes its byte into the buffer RAM at lane times
// element_count plus element; an emit transfer (mode 1) reads the buffer in
// order once the whole block is loaded and flags the final byte with
// out_last, after which a new block may be loaded. Loading past the block
// size, emitting before the block is complete, an empty block or a block
// larger than the 4096-byte buffer all answer with status 1 and leave the
// state alone. The block sustains one transfer per clock while responses are
// taken: each transfer costs at most one write or one read of the single
// buffer RAM, and the response passes through the read stage (the RAM's read
// register) and the output register. The request side keeps accepting while
// a finished response waits, as long as the read stage is empty; with both
// the read stage and the output register full, req_ready drops until the
// response is taken. Writing either register restarts the block; write
// registers only while no transfer is in flight. The buffer needs no clearing
// after reset: an entry is only ever emitted after it was loaded in the same
// block.
// ----------------------------------------------------------------------------
module byte_shuffle_transpose (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bst_pkg::req_payload_type        req_payload,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bst_pkg::rsp_payload_type        rsp_payload,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bst_pkg::PADDR_W-1:0]     paddr,
   input  logic [bst_pkg::PDATA_W-1:0]     pwdata,
   output logic [bst_pkg::PDATA_W-1:0]     prdata,
   output logic                            pready
);

   // Configuration registers
   logic [bst_pkg::TYPE_CODE_W-1:0]  type_size_code_ff;
   logic [bst_pkg::ELEM_COUNT_W-1:0] element_count_ff;

   // Block positions
   logic [bst_pkg::POS_W-1:0] load_pos_ff, load_pos_in;
   logic [bst_pkg::POS_W-1:0] emit_pos_ff, emit_pos_in;

   // Read stage and output register
   bst_pkg::stage_type        s1_ff, s1_in;
   logic                      rsp_valid_ff;
   bst_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   // Datapath
   logic                              csr_write;
   logic [bst_pkg::SHIFT_W-1:0]       shift;
   logic [bst_pkg::CALC_W-1:0]        total;
   logic                              block_ok;
   logic [bst_pkg::CALC_W-1:0]        load_pos_ext, emit_pos_ext, emit_next;
   logic [bst_pkg::CALC_W-1:0]        elem;
   logic [bst_pkg::LANE_W-1:0]        lane;
   logic [bst_pkg::CALC_W-1:0]        lane_mask;
   logic [bst_pkg::CALC_W-1:0]        waddr_full;
   logic                              load_ok, emit_ok, emit_last;
   logic                              s1_advance, accept;
   logic                              ram_we, ram_re;
   logic [7:0]                        ram_rdata;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   // Register read-back
   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         bst_pkg::REG_TYPE_SIZE:  prdata = bst_pkg::PDATA_W'(type_size_code_ff);
         bst_pkg::REG_ELEM_COUNT: prdata = bst_pkg::PDATA_W'(element_count_ff);
         default:                 prdata = '0;
      endcase
   end

   // Block size and position checks
   always_comb begin
      shift        = bst_pkg::SHIFT_W'(type_size_code_ff) + 1'b1;
      total        = bst_pkg::CALC_W'(element_count_ff) << shift;
      block_ok     = (total != '0) && (total <= bst_pkg::CALC_W'(bst_pkg::BUF_BYTES));
      load_pos_ext = bst_pkg::CALC_W'(load_pos_ff);
      emit_pos_ext = bst_pkg::CALC_W'(emit_pos_ff);
      emit_next    = emit_pos_ext + 1'b1;

      load_ok   = block_ok && (req_payload.mode == bst_pkg::MODE_LOAD)
                  && (load_pos_ext < total);
      emit_ok   = block_ok && (req_payload.mode == bst_pkg::MODE_EMIT)
                  && (load_pos_ext >= total) && (emit_pos_ext < total);
      emit_last = emit_next == total;

      // split the load position into element and byte lane
      elem       = load_pos_ext >> shift;
      lane_mask  = (bst_pkg::CALC_W'(1) << shift) - 1'b1;
      lane       = bst_pkg::LANE_W'(load_pos_ext & lane_mask);
      waddr_full = bst_pkg::CALC_W'(lane * element_count_ff) + elem;
   end

   // Handshake: the read stage moves on when the output register is free
   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_ff.valid || s1_advance;
   assign accept     = req_valid && req_ready;
   assign ram_we     = accept && load_ok;
   assign ram_re     = accept && emit_ok;

   // Next positions and read-stage flags
   always_comb begin
      load_pos_in = load_pos_ff;
      emit_pos_in = emit_pos_ff;
      if (ram_we) begin
         load_pos_in = load_pos_ff + 1'b1;
      end else if (ram_re) begin
         if (emit_last) begin
            // block done: restart both positions
            load_pos_in = '0;
            emit_pos_in = '0;
         end else begin
            emit_pos_in = bst_pkg::POS_W'(emit_next);
         end
      end

      s1_in.valid  = accept;
      s1_in.rd     = ram_re;
      s1_in.last   = ram_re && emit_last;
      s1_in.status = (load_ok || emit_ok) ? bst_pkg::STATUS_OK : bst_pkg::STATUS_ERR;

      rsp_payload_in.out_byte = s1_ff.rd ? ram_rdata : 8'h00;
      rsp_payload_in.out_last = s1_ff.last;
      rsp_payload_in.status   = s1_ff.status;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         type_size_code_ff <= '0;
         element_count_ff  <= '0;
         load_pos_ff       <= '0;
         emit_pos_ff       <= '0;
         s1_ff             <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            // any register write restarts the block
            unique case (paddr[2])
               bst_pkg::REG_TYPE_SIZE:
                  type_size_code_ff <= pwdata[bst_pkg::TYPE_CODE_W-1:0];
               bst_pkg::REG_ELEM_COUNT:
                  element_count_ff  <= pwdata[bst_pkg::ELEM_COUNT_W-1:0];
               default: ;
            endcase
            load_pos_ff <= '0;
            emit_pos_ff <= '0;
         end else begin
            load_pos_ff <= load_pos_in;
            emit_pos_ff <= emit_pos_in;
         end
         if (req_ready) begin
            s1_ff <= s1_in;
         end
         if (s1_advance) begin
            rsp_valid_ff <= s1_ff.valid;
         end
      end
   end

   // Response payload: hold while stalled
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Transposed byte buffer
   bst_ram #(
      .WIDTH (8),
      .DEPTH (bst_pkg::BUF_BYTES)
   ) u_buffer (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr_full[bst_pkg::ADDR_W-1:0]),
      .wdata (req_payload.data_byte),
      .re    (ram_re),
      .raddr (emit_pos_ff[bst_pkg::ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

endmodule
